[rtl/idll_pkg.sv]
`timescale 1ns / 1ps

package idll_pkg;

	localparam int LINK_W = 10;

	localparam logic [1:0] KIND_UNLINK = 2'd0;
	localparam logic [1:0] KIND_BEFORE = 2'd1;
	localparam logic [1:0] KIND_AFTER  = 2'd2;
	localparam logic [1:0] KIND_QUERY  = 2'd3;

	typedef logic [LINK_W-1:0] link_t;

	typedef struct packed {
		logic [1:0] kind;
		link_t      target_node;
		link_t      moved_node;
	} idll_req_t;

	typedef struct packed {
		link_t prev_node;
		link_t next_node;
	} idll_rsp_t;

endpackage

[rtl/idll_chan_if.sv]
`timescale 1ns / 1ps

interface idll_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[rtl/indexed_doubly_linked_list_top.sv]
`timescale 1ns / 1ps

// Indexed doubly linked list over node numbers, 0 meaning none.
// req channel: kind, target_node, moved_node. kind selects unlink, insert
// before, insert after or query. Only a query yields a transaction on rsp,
// carrying the target's prev_node and next_node (both 0 for an invalid node).
// Links live in two single-port-write RAMs (pred and succ) with registered
// reads. Each item is read, then for unlink or insert written back, one
// item at a time:
//   unlink / insert : read, neighbour/self write, second write
//   query           : read, then result registered once rsp is free
// After arst_n is released a clearing pass zeroes both RAMs, one entry per
// cycle, over every entry; req.ready stays low during it.
// rsp is an output register: a pending result does not block further
// unlinks or inserts. A query that finds the register still full waits in its
// read stage until rsp.ready frees it, holding req.ready low meanwhile.
module indexed_doubly_linked_list_top #(
	parameter int NODE_COUNT = 1024
) (
	input logic clk,
	input logic arst_n,
	idll_chan_if.sink   req,
	idll_chan_if.source rsp
);
	import idll_pkg::*;

	localparam int AW   = $clog2(NODE_COUNT);
	localparam int NCW  = $clog2(NODE_COUNT + 1);
	localparam int CMPW = (NCW > LINK_W) ? NCW : LINK_W;

	localparam logic [1:0] ST_CLR  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_WA   = 2'd2;
	localparam logic [1:0] ST_WB   = 2'd3;

	function automatic logic is_node(input link_t v);
		is_node = (v != '0) && (CMPW'(v) < CMPW'(NODE_COUNT));
	endfunction

	logic [1:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [1:0]    kind_q;
	link_t         t_q;
	link_t         m_q;
	logic          t_ok_q;
	logic          op_en_q;
	link_t         p_q;
	link_t         n_q;
	idll_rsp_t     rsp_q;
	logic          rsp_valid_q;

	logic          accept;
	logic          op_en_d;
	logic          rsp_load;
	logic [AW-1:0] raddr;
	link_t         rd_p;
	link_t         rd_n;
	logic          pred_we;
	logic [AW-1:0] pred_wa;
	link_t         pred_wd;
	logic          succ_we;
	logic [AW-1:0] succ_wa;
	link_t         succ_wd;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	assign op_en_d = is_node(req.data.target_node) &&
		((req.data.kind == KIND_UNLINK) ||
		 ((req.data.kind == KIND_BEFORE || req.data.kind == KIND_AFTER) &&
		  is_node(req.data.moved_node) &&
		  (req.data.moved_node != req.data.target_node)));

	assign rsp_load = (state_q == ST_WA) && (kind_q == KIND_QUERY) &&
		(!rsp_valid_q || rsp.ready);

	// read at the incoming target while idle, then hold it
	assign raddr = (state_q == ST_IDLE) ? AW'(req.data.target_node) : AW'(t_q);

	always_comb begin
		pred_we = 1'b0;
		pred_wa = AW'(t_q);
		pred_wd = '0;
		succ_we = 1'b0;
		succ_wa = AW'(t_q);
		succ_wd = '0;
		case (state_q)
			ST_CLR: begin
				pred_we = 1'b1;
				pred_wa = clr_q;
				succ_we = 1'b1;
				succ_wa = clr_q;
			end
			ST_WA: begin
				case (kind_q)
					KIND_UNLINK: begin
						// join the neighbours
						pred_we = op_en_q && is_node(rd_n);
						pred_wa = AW'(rd_n);
						pred_wd = rd_p;
						succ_we = op_en_q && is_node(rd_p);
						succ_wa = AW'(rd_p);
						succ_wd = rd_n;
					end
					KIND_BEFORE: begin
						pred_we = op_en_q;
						pred_wa = AW'(m_q);
						pred_wd = rd_p;
						succ_we = op_en_q;
						succ_wa = AW'(m_q);
						succ_wd = t_q;
					end
					KIND_AFTER: begin
						pred_we = op_en_q;
						pred_wa = AW'(m_q);
						pred_wd = t_q;
						succ_we = op_en_q;
						succ_wa = AW'(m_q);
						succ_wd = rd_n;
					end
					default: begin
					end
				endcase
			end
			ST_WB: begin
				case (kind_q)
					KIND_UNLINK: begin
						pred_we = op_en_q;
						succ_we = op_en_q;
					end
					KIND_BEFORE: begin
						// moved node already ahead of target: its pred and succ now point at itself
						pred_we = op_en_q;
						pred_wa = (p_q == m_q) ? AW'(m_q) : AW'(t_q);
						pred_wd = m_q;
						succ_we = op_en_q && is_node(p_q);
						succ_wa = AW'(p_q);
						succ_wd = m_q;
					end
					KIND_AFTER: begin
						succ_we = op_en_q;
						succ_wd = m_q;
						pred_we = op_en_q && is_node(n_q);
						pred_wa = AW'(n_q);
						pred_wd = m_q;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	idll_ram #(.WIDTH(LINK_W), .DEPTH(NODE_COUNT)) u_pred_ram (
		.clk   (clk),
		.we    (pred_we),
		.waddr (pred_wa),
		.wdata (pred_wd),
		.raddr (raddr),
		.rdata (rd_p)
	);

	idll_ram #(.WIDTH(LINK_W), .DEPTH(NODE_COUNT)) u_succ_ram (
		.clk   (clk),
		.we    (succ_we),
		.waddr (succ_wa),
		.wdata (succ_wd),
		.raddr (raddr),
		.rdata (rd_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(NODE_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_WA;
					end
				end
				ST_WA: begin
					if (kind_q != KIND_QUERY) begin
						state_q <= ST_WB;
					end else if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WB: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= req.data.kind;
			t_q     <= req.data.target_node;
			m_q     <= req.data.moved_node;
			t_ok_q  <= is_node(req.data.target_node);
			op_en_q <= op_en_d;
		end
		if (state_q == ST_WA) begin
			p_q <= rd_p;
			n_q <= rd_n;
		end
		if (rsp_load) begin
			rsp_q.prev_node <= t_ok_q ? rd_p : '0;
			rsp_q.next_node <= t_ok_q ? rd_n : '0;
		end
	end

	a_accept_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_WA)
		else $error("accepted transaction did not enter read stage");

	a_rsp_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_WA && $past(kind_q) == KIND_QUERY)
		else $error("response raised without a query");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pred_we && !succ_we)
		else $error("table write while idle");

	a_unlink_clears_self: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WB && kind_q == KIND_UNLINK && op_en_q) |->
			pred_we && succ_we && pred_wd == '0 && succ_wd == '0 &&
			pred_wa == AW'(t_q) && succ_wa == AW'(t_q))
		else $error("unlink did not clear target links");

	a_query_holds_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WA && kind_q == KIND_QUERY && !rsp_load) |=>
			state_q == ST_WA && $stable(t_q))
		else $error("stalled query lost its read");

endmodule

[rtl/idll_ram.sv]
`timescale 1ns / 1ps

module idll_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
